// ===== sv/rtks_pkg.sv =====
// ----------------------------------------------------------------------------
// rtks_pkg - transmit keying sequencer shared definitions
// Word layouts, state and code names, register indexes and thresholds.
// ----------------------------------------------------------------------------
package rtks_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_OFF   = 2'd0,
        ST_DELAY = 2'd1,
        ST_ON    = 2'd2,
        ST_TAIL  = 2'd3
    } seq_state_t;

    // request modes
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_DATA_REQ = 2'd1;
    localparam logic [1:0] MODE_CHAR_REQ = 2'd2;
    localparam logic [1:0] MODE_NONE     = 2'd3;

    // key actions
    localparam logic [1:0] KEY_NONE = 2'd0;
    localparam logic [1:0] KEY_ON   = 2'd1;
    localparam logic [1:0] KEY_OFF  = 2'd2;

    // frame kinds
    localparam logic [2:0] FRAME_NONE       = 3'd0;
    localparam logic [2:0] FRAME_SILENCE    = 3'd1;
    localparam logic [2:0] FRAME_VOICE      = 3'd2;
    localparam logic [2:0] FRAME_VOICE_SWAP = 3'd3;
    localparam logic [2:0] FRAME_PACKET     = 3'd4;

    // data payload kinds
    localparam logic [1:0] PAYLOAD_HEADER   = 2'd0;
    localparam logic [1:0] PAYLOAD_POSITION = 2'd1;
    localparam logic [1:0] PAYLOAD_PACKET   = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_FULL_DUPLEX    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELAY_PERIODS  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TAIL_PERIODS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_PERIODS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_MAX     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_PERIODS    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_CODEC_PRESENT  = 3'd6;

    // speech energy thresholds, unsigned 8.8 (15.0 and 1.0)
    localparam logic [15:0] ENERGY_DATA_LIMIT = 16'd3840;
    localparam logic [15:0] ENERGY_IDLE_LIMIT = 16'd256;

    // position counter, 18-bit two's complement, saturating high
    localparam int POS_W = 18;
    localparam logic signed [POS_W-1:0] POS_MAX = 18'sd131071;

    typedef struct packed {
        logic [1:0]  mode;
        logic        voice_ready;
        logic        data_ready;
        logic        control_ready;
        logic        carrier_detect;
        logic        modem_backlog;
        logic        fix_valid;
        logic [15:0] speech_energy;
        logic [7:0]  control_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0] key_action;
        logic [2:0] frame_kind;
        logic [1:0] payload_kind;
        logic [6:0] char_out;
        logic       transmitting;
    } out_word_t;

endpackage

// ===== sv/rtks_word_if.sv =====
// ----------------------------------------------------------------------------
// rtks_word_if - valid/ready word channel
// Carries one word per handshake; the word type is set per instance.
// ----------------------------------------------------------------------------
interface rtks_word_if #(parameter type word_t = logic) ();
    logic  valid;
    logic  ready;
    word_t word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

// ===== sv/radio_tx_keying_sequencer.sv =====
// ----------------------------------------------------------------------------
// radio_tx_keying_sequencer - transmit keying sequencer
// Keys the transmitter through off, key-up delay, on and tail, and picks the
// frame, data payload or control character for each request word.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word per handshake: a frame tick, a data slot
//   request or a control character request, with the queue and carrier flags.
//   rsp returns exactly one result word per request, in order.
//   The wr_* port writes the seven configuration registers; write only while
//   the block is idle.
// Timing:
//   a request is captured in an input register and evaluated in one pass of
//   logic into the result register, from which its result is offered on rsp.
//   One word is taken every cycle unless rsp is held off; the sequencer state
//   is updated in that same single pass, so consecutive words need not wait for it.
// Reset:
//   state off, all counters and the character-busy flag clear, registers at
//   their reset values (codec_present set), both stages empty.
// Stall:
//   while rsp is held off the result waits in its register; one more word is
//   still taken into the input register, after which req.ready drops.
// ----------------------------------------------------------------------------
module radio_tx_keying_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    rtks_word_if.sink                           req,
    rtks_word_if.source                         rsp,
    input  logic                                wr_en,
    input  logic [rtks_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [rtks_pkg::CFG_DATA_W-1:0]     wr_data
);

    // configuration registers
    logic        full_duplex_reg;
    logic [15:0] delay_periods_reg;
    logic [15:0] tail_periods_reg;
    logic [15:0] header_periods_reg;
    logic [15:0] header_max_reg;
    logic [15:0] pos_periods_reg;
    logic        codec_present_reg;

    // sequencer state
    rtks_pkg::seq_state_t               state_reg, state_next;
    logic [15:0]                        period_reg, period_next;
    logic [15:0]                        header_reg, header_next;
    logic signed [rtks_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                               busy_reg, busy_next;

    // pipeline
    logic                 in_valid_reg;
    rtks_pkg::in_word_t   in_word_reg;
    logic                 out_valid_reg;
    rtks_pkg::out_word_t  out_word_reg;
    rtks_pkg::out_word_t  out_word_next;
    logic                 advance;

    // working values
    logic [15:0]                        period_inc;
    logic signed [rtks_pkg::POS_W-1:0]  pos_limit;
    logic signed [rtks_pkg::POS_W-1:0]  pos_entry;
    logic                               any_traffic;
    logic                               late_now;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.word  = out_word_reg;

    // frame kind when data or voice goes out, from updated counts
    function automatic logic [2:0] send_frame(
        input rtks_pkg::in_word_t              w,
        input logic [15:0]                     hc,
        input logic signed [rtks_pkg::POS_W-1:0] pc,
        input logic signed [rtks_pkg::POS_W-1:0] plim,
        input logic [15:0]                     hp,
        input logic [15:0]                     hmax,
        input logic                            codec,
        input logic                            busy
    );
        logic data_due;
        logic send_data;
        data_due = (w.fix_valid && (pc >= plim)) || w.data_ready || (hc >= hp);
        send_data = hc >= hmax;
        if (codec)
        begin
            send_data = send_data
                || (data_due && (w.speech_energy < rtks_pkg::ENERGY_DATA_LIMIT))
                || (!busy && (w.speech_energy < rtks_pkg::ENERGY_IDLE_LIMIT));
        end
        if (!w.voice_ready)
            return rtks_pkg::FRAME_PACKET;
        return send_data ? rtks_pkg::FRAME_VOICE_SWAP : rtks_pkg::FRAME_VOICE;
    endfunction

    assign period_inc  = (&period_reg) ? period_reg : period_reg + 16'd1;
    assign pos_limit   = $signed({2'b00, pos_periods_reg});
    assign pos_entry   = $signed({2'b00, pos_periods_reg})
                       - $signed({2'b00, header_periods_reg})
                       - $signed({{(rtks_pkg::POS_W-1){1'b0}}, 1'b1});
    assign any_traffic = in_word_reg.voice_ready || in_word_reg.data_ready;
    assign late_now    = in_word_reg.fix_valid && (pos_reg >= pos_limit);

    // single-pass step of the sequencer
    always_comb
    begin
        state_next    = state_reg;
        period_next   = period_reg;
        header_next   = header_reg;
        pos_next      = pos_reg;
        busy_next     = busy_reg;
        out_word_next = '0;

        unique case (in_word_reg.mode)
            rtks_pkg::MODE_TICK:
            begin
                period_next = period_inc;
                unique case (state_reg) inside
                    rtks_pkg::ST_OFF,
                    rtks_pkg::ST_DELAY:
                    begin
                        if ((state_reg == rtks_pkg::ST_OFF)
                            && !(any_traffic
                                 && (!in_word_reg.carrier_detect || full_duplex_reg)))
                        begin
                            out_word_next.frame_kind = rtks_pkg::FRAME_SILENCE;
                        end
                        else
                        begin
                            if (state_reg == rtks_pkg::ST_OFF)
                            begin
                                state_next = rtks_pkg::ST_DELAY;
                                period_next = '0;
                                out_word_next.key_action = rtks_pkg::KEY_ON;
                            end
                            if (period_next >= delay_periods_reg)
                            begin
                                state_next  = rtks_pkg::ST_ON;
                                period_next = '0;
                                header_next = '0;
                                pos_next    = pos_entry;
                            end
                            out_word_next.frame_kind = send_frame(in_word_reg,
                                header_next, pos_next, pos_limit, header_periods_reg,
                                header_max_reg, codec_present_reg, busy_reg);
                        end
                    end
                    rtks_pkg::ST_ON:
                    begin
                        if (!any_traffic && !in_word_reg.modem_backlog && !busy_reg)
                        begin
                            state_next  = rtks_pkg::ST_TAIL;
                            period_next = '0;
                        end
                        header_next = (&header_reg) ? header_reg : header_reg + 16'd1;
                        if (pos_reg < rtks_pkg::POS_MAX)
                            pos_next = pos_reg + $signed({{(rtks_pkg::POS_W-1){1'b0}}, 1'b1});
                        out_word_next.frame_kind = send_frame(in_word_reg,
                            header_next, pos_next, pos_limit, header_periods_reg,
                            header_max_reg, codec_present_reg, busy_reg);
                    end
                    default:
                    begin
                        if (period_inc >= tail_periods_reg)
                        begin
                            state_next  = rtks_pkg::ST_OFF;
                            period_next = '0;
                            out_word_next.key_action = rtks_pkg::KEY_OFF;
                        end
                        else
                        begin
                            if (any_traffic)
                            begin
                                state_next  = rtks_pkg::ST_ON;
                                period_next = '0;
                            end
                            out_word_next.frame_kind = send_frame(in_word_reg,
                                header_reg, pos_reg, pos_limit, header_periods_reg,
                                header_max_reg, codec_present_reg, busy_reg);
                        end
                    end
                endcase
            end
            rtks_pkg::MODE_DATA_REQ:
            begin
                if (state_reg == rtks_pkg::ST_ON)
                begin
                    if ((!in_word_reg.data_ready && !late_now)
                        || (header_reg >= header_periods_reg))
                    begin
                        header_next = '0;
                        out_word_next.payload_kind = rtks_pkg::PAYLOAD_HEADER;
                    end
                    else if (late_now)
                    begin
                        pos_next = '0;
                        out_word_next.payload_kind = rtks_pkg::PAYLOAD_POSITION;
                    end
                    else
                    begin
                        out_word_next.payload_kind = rtks_pkg::PAYLOAD_PACKET;
                    end
                end
            end
            rtks_pkg::MODE_CHAR_REQ:
            begin
                if (in_word_reg.control_ready && (state_reg == rtks_pkg::ST_ON))
                begin
                    busy_next = 1'b1;
                    // a byte with the top bit set goes out as zero
                    out_word_next.char_out = in_word_reg.control_byte[7]
                                           ? 7'd0 : in_word_reg.control_byte[6:0];
                end
                else
                begin
                    busy_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        out_word_next.transmitting = (state_next != rtks_pkg::ST_OFF);
    end

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_duplex_reg    <= 1'b0;
            delay_periods_reg  <= '0;
            tail_periods_reg   <= '0;
            header_periods_reg <= '0;
            header_max_reg     <= '0;
            pos_periods_reg    <= '0;
            codec_present_reg  <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                rtks_pkg::REG_FULL_DUPLEX:    full_duplex_reg    <= wr_data[0];
                rtks_pkg::REG_DELAY_PERIODS:  delay_periods_reg  <= wr_data;
                rtks_pkg::REG_TAIL_PERIODS:   tail_periods_reg   <= wr_data;
                rtks_pkg::REG_HEADER_PERIODS: header_periods_reg <= wr_data;
                rtks_pkg::REG_HEADER_MAX:     header_max_reg     <= wr_data;
                rtks_pkg::REG_POS_PERIODS:    pos_periods_reg    <= wr_data;
                rtks_pkg::REG_CODEC_PRESENT:  codec_present_reg  <= wr_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer state and stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtks_pkg::ST_OFF;
            period_reg    <= '0;
            header_reg    <= '0;
            pos_reg       <= '0;
            busy_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
            begin
                state_reg  <= state_next;
                period_reg <= period_next;
                header_reg <= header_next;
                pos_reg    <= pos_next;
                busy_reg   <= busy_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            in_word_reg <= req.word;
        if (advance)
            out_word_reg <= out_word_next;
    end

    // checks
    a_busy_only_on: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (state_reg == rtks_pkg::ST_ON))
        else $error("character busy outside on state");

    a_key_on_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_word_reg.key_action == rtks_pkg::KEY_ON))
        |-> out_word_reg.transmitting)
        else $error("key on without transmitting");

    a_key_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_word_reg.key_action == rtks_pkg::KEY_OFF))
        |-> (!out_word_reg.transmitting
             && (out_word_reg.frame_kind == rtks_pkg::FRAME_NONE)))
        else $error("key off with frame or transmitting");

    a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_word_reg.frame_kind != rtks_pkg::FRAME_NONE))
        |-> ((out_word_reg.payload_kind == rtks_pkg::PAYLOAD_HEADER)
             && (out_word_reg.char_out == 7'd0)))
        else $error("tick result carries payload or character");

    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !rsp.ready) |-> !req.ready)
        else $error("request taken with both stages full");

endmodule
